// ----- sv/sam_pkg.sv -----
// ----------------------------------------------------------------------------
// sam_pkg: shared types and codes for the suffix automaton builder
// Operation codes shared by the block and its bench.
// ----------------------------------------------------------------------------
package sam_pkg;

	typedef enum logic [1:0] {
		OP_START_STR = 2'd0,
		OP_APPEND    = 2'd1,
		OP_START_QRY = 2'd2,
		OP_QUERY     = 2'd3
	} op_t;

endpackage

// ----- sv/sam_ram.sv -----
// ----------------------------------------------------------------------------
// sam_ram: single-port table memory with registered read
// One address per cycle, read and optionally written; read data appears the cycle after.
// ----------------------------------------------------------------------------
module sam_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// read before write: a read at the written address returns the old word
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ----- sv/suffix_automaton_builder.sv -----
// ----------------------------------------------------------------------------
// suffix_automaton_builder: generalised suffix automaton over a letter set
// Online construction with cloning, plus substring membership walks.
// ----------------------------------------------------------------------------
// Usage: one input word (operation, symbol) in over valid/ready, one result
// word (state_index, matched, overflow) out over valid/ready per input.
// From the accepting edge, start string, start query, a refused or
// out-of-range append and a query on a dead walk go straight to the result;
// a live query symbol first makes one table read. An append reads and then
// writes at each state it visits along the suffix links, and reads the
// length of the target when an existing edge is found. A clone then copies
// the transitions with a read and a write per letter and redirects each
// edge with a read and a write. The single-port tables set this sequence.
// With the result taken at once the next word is accepted the cycle after.
// After reset a clearing pass sweeps all tables, one address a cycle, and
// no input is taken meanwhile.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new input word until it has been accepted.
// ----------------------------------------------------------------------------
module suffix_automaton_builder #(
	parameter int MAX_STATES = 4096,
	parameter int ALPHABET   = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [4:0]  symbol,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] state_index,
	output logic        matched,
	output logic        overflow
);
	import sam_pkg::*;

	localparam int SW = $clog2(MAX_STATES);
	localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int TD = MAX_STATES * ALPHABET;
	localparam int TW = $clog2(TD);

	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_QRD   = 14'b00000000000100, // read trans[cur][c]
		S_QWT   = 14'b00000000001000,
		S_WRD   = 14'b00000000010000, // walk: read trans[p][c], link[p], len[p]
		S_WWT   = 14'b00000000100000, // walk: write edge to np or stop
		S_ALQ   = 14'b00000001000000, // read len[q]
		S_ACHK  = 14'b00000010000000, // decide extend / clone
		S_CLR   = 14'b00000100000000, // clone: read link[q], write len[nq]
		S_CPR   = 14'b00001000000000, // copy transition read
		S_CPW   = 14'b00010000000000, // copy transition write
		S_RRD   = 14'b00100000000000, // redirect read
		S_RWT   = 14'b01000000000000, // redirect write or stop
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t st_q;
	// first step of an append; np has been created
	logic          first_q, ins_q;
	logic [SW-1:0] last_q, cnt_q, qcur_q, p_q, q_q, np_q, nq_q;
	logic          qalive_q;
	logic [AW-1:0] c_q, k_q;
	logic [SW-1:0] lenp1_q;
	logic [TW-1:0] clr_q;
	logic [11:0]   idx_q;
	logic          mat_q, ovf_q;

	// table ports
	logic          t_we, l_we, n_we;
	logic [TW-1:0] t_addr;
	logic [SW-1:0] t_wd, t_rd, l_addr, l_wd, l_rd, n_addr, n_wd, n_rd;

	sam_ram #(.DEPTH(TD), .WIDTH(SW)) u_trans (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));
	sam_ram #(.DEPTH(MAX_STATES), .WIDTH(SW)) u_link (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
	sam_ram #(.DEPTH(MAX_STATES), .WIDTH(SW)) u_len (
		.clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd));

	function automatic logic [TW-1:0] taddr(logic [SW-1:0] s, logic [AW-1:0] a);
		return TW'(s) * TW'(ALPHABET) + TW'(a);
	endfunction

	assign in_ready    = (st_q == S_IDLE);
	assign out_valid   = (st_q == S_OUT);
	assign state_index = idx_q;
	assign matched     = mat_q;
	assign overflow    = ovf_q;

	logic [SW-1:0] cap;
	logic          sym_ok;
	assign cap    = SW'(MAX_STATES - 3);
	assign sym_ok = ({4'b0, symbol} < 9'(ALPHABET));

	// memory port drive
	always_comb begin
		t_we = 1'b0; l_we = 1'b0; n_we = 1'b0;
		t_addr = taddr(p_q, c_q); t_wd = np_q;
		l_addr = p_q; l_wd = '0; n_addr = p_q; n_wd = lenp1_q;
		case (st_q)
			S_CLEAR: begin
				t_we = 1'b1; t_addr = clr_q; t_wd = '0;
				l_we = clr_q < TW'(MAX_STATES); l_addr = clr_q[SW-1:0];
				n_we = l_we; n_addr = clr_q[SW-1:0]; n_wd = '0;
			end
			S_QRD: t_addr = taddr(qcur_q, c_q);
			S_WWT: begin
				if (t_rd == '0) begin
					// edge on c from p goes to the new state
					t_we = 1'b1;
					if (first_q) begin
						n_we = 1'b1; n_addr = np_q; n_wd = n_rd + SW'(1);
					end
					// walked past the root: np links to the root
					if (l_rd == '0) begin
						l_we = 1'b1; l_addr = np_q; l_wd = SW'(1);
					end
				end
			end
			S_ALQ: n_addr = q_q;
			S_ACHK: begin
				if (n_rd == lenp1_q && ins_q) begin
					l_we = 1'b1; l_addr = np_q; l_wd = q_q;
				end
			end
			S_CLR: begin
				l_addr = q_q;
				n_we = 1'b1; n_addr = nq_q; n_wd = lenp1_q;
			end
			S_CPR: begin
				t_addr = taddr(q_q, k_q);
				// link of q was read in the previous cycle
				if (k_q == '0) begin
					l_we = 1'b1; l_addr = nq_q; l_wd = l_rd;
				end
			end
			S_CPW: begin
				t_we = 1'b1; t_addr = taddr(nq_q, k_q); t_wd = t_rd;
				if (k_q == '0) begin
					l_we = 1'b1; l_addr = q_q; l_wd = nq_q;
				end else if (k_q == AW'(1) && ins_q) begin
					l_we = 1'b1; l_addr = np_q; l_wd = nq_q;
				end
			end
			S_RWT: begin
				if (t_rd == q_q) begin
					t_we = 1'b1; t_wd = nq_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR; clr_q <= '0;
			last_q <= SW'(1); cnt_q <= SW'(1); qcur_q <= SW'(1); qalive_q <= 1'b1;
			first_q <= 1'b0; ins_q <= 1'b0;
			p_q <= '0; q_q <= '0; np_q <= '0; nq_q <= '0; c_q <= '0; k_q <= '0;
			lenp1_q <= '0; idx_q <= '0; mat_q <= 1'b0; ovf_q <= 1'b0;
		end else begin
			case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + TW'(1);
					if (clr_q == TW'(TD - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					c_q <= AW'(symbol);
					mat_q <= 1'b0; ovf_q <= 1'b0;
					case (op_t'(operation))
						OP_START_STR: begin
							last_q <= SW'(1); idx_q <= 12'd1; st_q <= S_OUT;
						end
						OP_START_QRY: begin
							qcur_q <= SW'(1); qalive_q <= 1'b1;
							idx_q <= 12'd1; mat_q <= 1'b1; st_q <= S_OUT;
						end
						OP_QUERY: begin
							if (qalive_q && sym_ok) st_q <= S_QRD;
							else begin
								qalive_q <= 1'b0; idx_q <= 12'(qcur_q); st_q <= S_OUT;
							end
						end
						default: begin
							idx_q <= 12'(last_q);
							if (!sym_ok) st_q <= S_OUT;
							else if (cnt_q > cap) begin
								ovf_q <= 1'b1; st_q <= S_OUT;
							end else begin
								p_q <= last_q; np_q <= cnt_q + SW'(1);
								first_q <= 1'b1; ins_q <= 1'b0;
								st_q <= S_WRD;
							end
						end
					endcase
				end
				S_QRD: st_q <= S_QWT;
				S_QWT: begin
					if (t_rd != '0) begin
						qcur_q <= t_rd; idx_q <= 12'(t_rd); mat_q <= 1'b1;
					end else begin
						qalive_q <= 1'b0; idx_q <= 12'(qcur_q); mat_q <= 1'b0;
					end
					st_q <= S_OUT;
				end
				// walk along suffix links from the last state
				S_WRD: st_q <= S_WWT;
				S_WWT: begin
					first_q <= 1'b0;
					if (t_rd == '0) begin
						if (first_q) begin
							cnt_q <= np_q; last_q <= np_q; ins_q <= 1'b1;
						end
						if (l_rd == '0) begin
							idx_q <= 12'(np_q); st_q <= S_OUT;
						end else begin
							p_q <= l_rd; st_q <= S_WRD;
						end
					end else begin
						q_q <= t_rd; lenp1_q <= n_rd + SW'(1); st_q <= S_ALQ;
					end
				end
				S_ALQ: st_q <= S_ACHK;
				S_ACHK: begin
					if (n_rd == lenp1_q) begin
						if (ins_q) idx_q <= 12'(np_q);
						else begin
							last_q <= q_q; idx_q <= 12'(q_q);
						end
						st_q <= S_OUT;
					end else begin
						nq_q <= cnt_q + SW'(1); cnt_q <= cnt_q + SW'(1);
						if (!ins_q) last_q <= cnt_q + SW'(1);
						k_q <= '0; st_q <= S_CLR;
					end
				end
				// copy q's transitions to the clone
				S_CLR: st_q <= S_CPR;
				S_CPR: st_q <= S_CPW;
				S_CPW: begin
					if (k_q == AW'(ALPHABET - 1)) st_q <= S_RRD;
					else begin
						k_q <= k_q + AW'(1); st_q <= S_CPR;
					end
				end
				// move edges on c that point at q over to the clone
				S_RRD: begin
					if (p_q == '0) begin
						idx_q <= 12'(last_q); st_q <= S_OUT;
					end else st_q <= S_RWT;
				end
				S_RWT: begin
					if (t_rd == q_q) begin
						p_q <= l_rd; st_q <= S_RRD;
					end else begin
						idx_q <= 12'(last_q); st_q <= S_OUT;
					end
				end
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/suffix_automaton_builder_chk.sv -----
// ----------------------------------------------------------------------------
// suffix_automaton_builder_chk: port-level checks
// Handshake and result-field properties seen on the top-level ports.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] state_index,
	input logic        matched,
	input logic        overflow
);
	// never ready for input while a result is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");

	// a stalled result holds its fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(state_index) && $stable(matched)
		&& $stable(overflow)) else $error("result changed under stall");

	// a refused append never reports a match
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(matched && overflow)) else $error("matched with overflow");

	// state index never points at the null state
	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_index != 12'd0) else $error("null state reported");
endmodule

bind suffix_automaton_builder suffix_automaton_builder_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .state_index(state_index),
	.matched(matched), .overflow(overflow));

// ----- tb/tb_suffix_automaton_builder.sv -----
// ----------------------------------------------------------------------------
// tb_suffix_automaton_builder: self-checking bench for the automaton builder
// Drives operation/symbol words with random gaps, predicts each result word
// from its own copy of the automaton, and compares field by field in order.
// ----------------------------------------------------------------------------
module tb_suffix_automaton_builder;
	timeunit 1ns;
	timeprecision 1ps;

	import sam_pkg::*;

	localparam int NSTATES   = 4096;
	localparam int NLETTERS  = 26;
	// clearing pass after reset sweeps NSTATES*NLETTERS addresses; margin on top
	localparam int STALL_LIMIT = 400000;

	typedef struct packed {
		logic [11:0] idx;
		logic        hit;
		logic        refused;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = '0;
	logic [4:0]  symbol = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [11:0] state_index;
	logic        matched;
	logic        overflow;

	// predicted automaton
	int edge_to [NSTATES][NLETTERS];
	int link_of [NSTATES];
	int len_of  [NSTATES];
	int tail_state = 1;
	int n_states = 1;
	int cursor = 1;
	bit alive = 1'b1;

	result_t pending_results[$];
	int      appended[$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      out_hold = 0;
	bit      calm = 1'b0;

	suffix_automaton_builder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .symbol(symbol),
		.out_valid(out_valid), .out_ready(out_ready),
		.state_index(state_index), .matched(matched), .overflow(overflow)
	);

	always #2 clk = ~clk;

	function automatic int gap_draw();
		return calm ? 0 : int'($urandom_range(0, 16));
	endfunction

	// copy q to a fresh state and move p's chain of edges on c over to it
	function automatic int split_state(int p, int c, int q);
		int nq;
		n_states++;
		nq = n_states;
		link_of[nq] = link_of[q];
		len_of[nq] = len_of[p] + 1;
		for (int a = 0; a < NLETTERS; a++)
			edge_to[nq][a] = edge_to[q][a];
		link_of[q] = nq;
		while (p != 0 && edge_to[p][c] == q) begin
			edge_to[p][c] = nq;
			p = link_of[p];
		end
		return nq;
	endfunction

	// online extension by one letter
	function automatic void extend(int c);
		int p;
		int q;
		int np;
		p = tail_state;
		q = edge_to[p][c];
		if (q != 0) begin
			if (len_of[q] == len_of[p] + 1) tail_state = q;
			else tail_state = split_state(p, c, q);
			return;
		end
		n_states++;
		np = n_states;
		tail_state = np;
		len_of[np] = len_of[p] + 1;
		while (p != 0 && edge_to[p][c] == 0) begin
			edge_to[p][c] = np;
			p = link_of[p];
		end
		if (p == 0) begin
			link_of[np] = 1;
			return;
		end
		q = edge_to[p][c];
		if (len_of[q] == len_of[p] + 1) link_of[np] = q;
		else link_of[np] = split_state(p, c, q);
	endfunction

	function automatic result_t predict_word(op_t op, int sym);
		result_t r;
		int nx;
		r = '0;
		case (op)
			OP_START_STR: begin
				tail_state = 1;
				r.idx = 12'(tail_state);
			end
			OP_APPEND: begin
				if (sym < NLETTERS) begin
					if (n_states + 2 > NSTATES - 1) r.refused = 1'b1;
					else extend(sym);
				end
				r.idx = 12'(tail_state);
			end
			OP_START_QRY: begin
				cursor = 1;
				alive = 1'b1;
				r.idx = 12'(cursor);
				r.hit = 1'b1;
			end
			default: begin
				if (alive) begin
					nx = (sym < NLETTERS) ? edge_to[cursor][sym] : 0;
					if (nx != 0) cursor = nx;
					else alive = 1'b0;
				end
				r.idx = 12'(cursor);
				r.hit = alive;
			end
		endcase
		return r;
	endfunction

	// send one word; valid stays up across back-to-back words
	task automatic send_word(op_t op, int sym);
		int gap;
		gap = gap_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		symbol <= 5'(sym);
		pending_results.push_back(predict_word(op, sym));
		if (op == OP_APPEND && sym < NLETTERS) appended.push_back(sym);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_string(string s);
		send_word(OP_START_STR, 0);
		foreach (s[i]) send_word(OP_APPEND, int'(s[i]) - 97);
	endtask

	task automatic send_query(string s);
		send_word(OP_START_QRY, 0);
		foreach (s[i]) send_word(OP_QUERY, int'(s[i]) - 97);
	endtask

	// result side: random stalls, ordered compare
	always @(posedge clk) begin
		result_t exp_r;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: idx=%0d matched=%0b overflow=%0b",
						state_index, matched, overflow);
			end else begin
				exp_r = pending_results.pop_front();
				if (state_index !== exp_r.idx || matched !== exp_r.hit
						|| overflow !== exp_r.refused) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp idx=%0d m=%0b o=%0b got idx=%0d m=%0b o=%0b",
							exp_r.idx, exp_r.hit, exp_r.refused,
							state_index, matched, overflow);
				end
			end
			out_hold = gap_draw();
			out_ready <= (out_hold == 0);
		end else if (!out_ready && arst_n) begin
			if (out_hold <= 1) out_ready <= 1'b1;
			out_hold--;
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// cloning cases, letter extremes, out-of-range letters
	task automatic test_directed_build();
		send_string("abcbc");
		send_string("abbb");
		send_word(OP_APPEND, 25);
		send_word(OP_APPEND, 26);
		send_word(OP_APPEND, 31);
		send_string("zza");
	endtask

	// matching, missing edge, out-of-range letter, dead walk
	task automatic test_directed_query();
		send_query("bcb");
		send_query("bbz");
		send_word(OP_QUERY, 30);
		send_word(OP_QUERY, 0);
		send_query("cq");
		send_word(OP_QUERY, 1);
	endtask

	// mostly real strings and walks over their substrings, some noise
	task automatic test_random_mix(int n_items);
		int sent;
		int kind;
		int n;
		int span;
		int pos;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 19) == 0) calm = ~calm;
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				n = $urandom_range(1, 12);
				span = ($urandom_range(0, 2) == 0) ? NLETTERS : $urandom_range(2, 3);
				send_word(OP_START_STR, $urandom_range(0, 31));
				for (int i = 0; i < n; i++) send_word(OP_APPEND, $urandom_range(0, span - 1));
				sent += n + 1;
			end else if (kind < 85 && appended.size() > 0) begin
				n = $urandom_range(1, 10);
				pos = $urandom_range(0, appended.size() - 1);
				send_word(OP_START_QRY, $urandom_range(0, 31));
				for (int i = 0; i < n; i++) begin
					if (pos + i < appended.size() && $urandom_range(0, 9) != 0)
						send_word(OP_QUERY, appended[pos + i]);
					else
						send_word(OP_QUERY, $urandom_range(0, 31));
				end
				sent += n + 1;
			end else begin
				send_word(op_t'($urandom_range(0, 3)), $urandom_range(0, 31));
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	// fill the state table until appends are refused
	task automatic test_fill_overflow();
		int run;
		run = 0;
		while (n_states + 2 <= NSTATES - 1) begin
			if (run == 0) begin
				send_word(OP_START_STR, 0);
				run = $urandom_range(20, 80);
			end
			send_word(OP_APPEND, $urandom_range(0, NLETTERS - 1));
			run--;
		end
		for (int i = 0; i < 6; i++) send_word(OP_APPEND, $urandom_range(0, 31));
		send_word(OP_START_STR, 0);
		send_word(OP_APPEND, 0);
		send_query("ab");
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_build();
		test_directed_query();
		test_random_mix(1750);
		test_fill_overflow();
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
